>>> design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the six-step commutator
// Phase roles per step, stage codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned FillW   = 16;
  localparam int unsigned RunW    = 4;
  localparam int unsigned SumW    = 17;
  localparam int unsigned StepW   = 3;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [StepW-1:0]   step_t;

  typedef enum logic [1:0] {
    STAGE_CHECK = 2'd0,
    STAGE_CROSS = 2'd1,
    STAGE_DELAY = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    PH_U = 2'd0,
    PH_V = 2'd1,
    PH_W = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HIGH_MIN  = 3'd0,
    REG_LOW_MAX   = 3'd1,
    REG_ZC_LEVEL  = 3'd2,
    REG_FILL      = 3'd3,
    REG_RUN_LEN   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    phase_e flt_ph;
    phase_e hi_ph;
    phase_e lo_ph;
  } roles_t;

  localparam sample_t       HIGH_MIN_RST = 12'd2457;
  localparam sample_t       LOW_MAX_RST  = 12'd1638;
  localparam sample_t       ZC_LEVEL_RST = 12'd2047;
  localparam logic [15:0]   FILL_RST     = 16'd10000;
  localparam logic [3:0]    RUN_LEN_RST  = 4'd3;
  localparam sample_t       PREV_RST     = 12'd2047;
  localparam logic [3:0]    RUN_MAX      = 4'd15;
  localparam step_t         STEP_FIRST   = 3'd0;
  localparam step_t         STEP_LAST    = 3'd5;

  // Floating, high and low phase for each commutation step.
  function automatic roles_t step_roles(step_t step);
    roles_t r;
    case (step)
      3'd0:    r = '{flt_ph: PH_U, hi_ph: PH_W, lo_ph: PH_V};
      3'd1:    r = '{flt_ph: PH_W, hi_ph: PH_U, lo_ph: PH_V};
      3'd2:    r = '{flt_ph: PH_V, hi_ph: PH_U, lo_ph: PH_W};
      3'd3:    r = '{flt_ph: PH_U, hi_ph: PH_V, lo_ph: PH_W};
      3'd4:    r = '{flt_ph: PH_W, hi_ph: PH_V, lo_ph: PH_U};
      3'd5:    r = '{flt_ph: PH_V, hi_ph: PH_W, lo_ph: PH_U};
      default: r = '{flt_ph: PH_U, hi_ph: PH_W, lo_ph: PH_V};
    endcase
    return r;
  endfunction

  function automatic sample_t pick_phase(phase_e p, sample_t u, sample_t v, sample_t w);
    sample_t s;
    case (p)
      PH_U:    s = u;
      PH_V:    s = v;
      PH_W:    s = w;
      default: s = u;
    endcase
    return s;
  endfunction

endpackage

>>> design/ssc_sample_if.sv
// ----------------------------------------------------------------------------
// ssc_sample_if: phase sample channel
// Valid/ready channel carrying one U/V/W converter sample triple per word.
// ----------------------------------------------------------------------------
interface ssc_sample_if;
  import ssc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_u;
  sample_t sample_v;
  sample_t sample_w;

  modport source (output valid, output sample_u, output sample_v, output sample_w,
                  input ready);
  modport sink   (input valid, input sample_u, input sample_v, input sample_w,
                  output ready);
endinterface

>>> design/ssc_result_if.sv
// ----------------------------------------------------------------------------
// ssc_result_if: commutation result channel
// Valid/ready channel carrying drive code, commutation flag and stage per word.
// ----------------------------------------------------------------------------
interface ssc_result_if;
  import ssc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] drive_code;
  logic             commutated;
  logic [1:0]       stage_now;

  modport source (output valid, output drive_code, output commutated, output stage_now,
                  input ready);
  modport sink   (input valid, input drive_code, input commutated, input stage_now,
                  output ready);
endinterface

>>> design/sensorless_six_step_commutator.sv
// Path: a sample word passes the input register, then the result register.
// Throughput: one sample word per cycle unless the result side stalls;
//   all per-sample work is a single pass of compare and 17-bit add logic
//   between the input and result registers.
// Reset (async, active low): step 0, checking stage, previous float 2047,
//   counters cleared, thresholds back to their default values.
// ----------------------------------------------------------------------------
// sensorless_six_step_commutator: back-EMF zero-crossing six-step commutation
// Per sample: check the floating phase slope, wait for the mid-level
// crossing, integrate the floating phase as a delay, then advance the step.
// ----------------------------------------------------------------------------
module sensorless_six_step_commutator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssc_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [ssc_pkg::CfgDatW-1:0]   cfg_wdata_i,
  ssc_sample_if.sink                    sample_i,
  ssc_result_if.source                  result_o
);
  import ssc_pkg::*;

  // Configuration registers
  sample_t      high_min_q, low_max_q, zc_level_q;
  logic [15:0]  fill_q;
  logic [3:0]   run_len_q;

  // Input register
  logic         in_valid_q;
  sample_t      u_q, v_q, w_q;

  // Commutation state
  step_t        step_q, step_d;
  stage_e       stage_q, stage_d;
  sample_t      prev_q, prev_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;

  // Result register
  logic             out_valid_q;
  logic [CodeW-1:0] drive_code_q, drive_code_d;
  logic             commutated_q;
  stage_e           stage_now_q;

  // Datapath
  roles_t       roles;
  sample_t      f, h, l;
  logic         falling;
  logic         in_check, band_ok, slope_ok, run_met, go_check;
  logic         cross_en, cross_ok, delay_en, delay_done, advance;
  logic [3:0]   cnt_inc;
  logic [SumW-1:0] sum_add;
  logic         out_adv, fire;

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_min_q <= HIGH_MIN_RST;
      low_max_q  <= LOW_MAX_RST;
      zc_level_q <= ZC_LEVEL_RST;
      fill_q     <= FILL_RST;
      run_len_q  <= RUN_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_HIGH_MIN: high_min_q <= cfg_wdata_i[SampleW-1:0];
        REG_LOW_MAX:  low_max_q  <= cfg_wdata_i[SampleW-1:0];
        REG_ZC_LEVEL: zc_level_q <= cfg_wdata_i[SampleW-1:0];
        REG_FILL:     fill_q     <= cfg_wdata_i[FillW-1:0];
        REG_RUN_LEN:  run_len_q  <= cfg_wdata_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  // The result register frees up when empty or when its word is taken.
  // The input register moves on whenever the result register can load.
  assign out_adv        = !out_valid_q || result_o.ready;
  assign fire           = in_valid_q && out_adv;
  assign sample_i.ready = !in_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      u_q <= sample_i.sample_u;
      v_q <= sample_i.sample_v;
      w_q <= sample_i.sample_w;
    end
  end

  // Pick the floating, high and low phases for the current step.
  assign roles   = step_roles(step_q);
  assign f       = pick_phase(roles.flt_ph, u_q, v_q, w_q);
  assign h       = pick_phase(roles.hi_ph,  u_q, v_q, w_q);
  assign l       = pick_phase(roles.lo_ph,  u_q, v_q, w_q);
  // Odd steps expect a falling floating phase, even steps a rising one.
  assign falling = step_q[0];

  // Slope check: both driven phases inside their bands, floating phase
  // moving strictly in the expected direction.
  assign in_check = (stage_q != STAGE_CROSS) && (stage_q != STAGE_DELAY);
  assign band_ok  = (h > high_min_q) && (l < low_max_q);
  assign slope_ok = falling ? (f < prev_q) : (f > prev_q);
  assign cnt_inc  = (cnt_q < RUN_MAX) ? cnt_q + 4'd1 : cnt_q;
  assign run_met  = cnt_inc >= run_len_q;
  assign go_check = in_check && band_ok && slope_ok && run_met;

  // Crossing and delay fall through in the same sample once reached.
  assign cross_en   = in_check ? go_check : (stage_q == STAGE_CROSS);
  assign cross_ok   = falling ? (f < zc_level_q) : (f > zc_level_q);
  assign delay_en   = (cross_en && cross_ok) || (stage_q == STAGE_DELAY);
  assign sum_add    = sum_q + {{(SumW-SampleW){1'b0}}, f};
  assign delay_done = sum_add >= {{(SumW-FillW){1'b0}}, fill_q};
  assign advance    = delay_en && delay_done;

  always_comb begin
    cnt_d  = cnt_q;
    prev_d = prev_q;
    sum_d  = sum_q;
    step_d = step_q;
    if (in_check) begin
      prev_d = f;
      if (band_ok) begin
        if (!slope_ok || run_met) begin
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
    end
    if (delay_en) begin
      sum_d = delay_done ? '0 : sum_add;
    end
    if (advance) begin
      step_d = (step_q == STEP_LAST) ? STEP_FIRST : step_q + 3'd1;
    end
  end

  always_comb begin
    if (advance) begin
      stage_d = STAGE_CHECK;
    end else if (delay_en) begin
      stage_d = STAGE_DELAY;
    end else if (cross_en) begin
      stage_d = STAGE_CROSS;
    end else begin
      stage_d = STAGE_CHECK;
    end
  end

  assign drive_code_d = step_d + 3'd1;

  // Advance the commutation state once per processed sample word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_FIRST;
      stage_q <= STAGE_CHECK;
      prev_q  <= PREV_RST;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else if (fire) begin
      step_q  <= step_d;
      stage_q <= stage_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  // Result register: hold while the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      drive_code_q <= drive_code_d;
      commutated_q <= advance;
      stage_now_q  <= stage_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.drive_code = drive_code_q;
  assign result_o.commutated = commutated_q;
  assign result_o.stage_now  = stage_now_q;

  // A shown word always carries a drive code of 1 to 6.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_code_q >= 3'd1) && (drive_code_q <= 3'd6))
    else $error("drive code out of range");

  // A commutation always returns the sequence to slope checking.
  a_comm_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && commutated_q) |-> (stage_now_q == STAGE_CHECK))
    else $error("commutation without return to checking");

  // The step only moves when a processed word commutates.
  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && advance) |=> $stable(step_q))
    else $error("step changed without commutation");

  // A partial delay sum only exists inside the delay stage.
  a_sum_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q != '0) |-> (stage_q == STAGE_DELAY))
    else $error("delay sum left outside the delay stage");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sensorless six-step commutator
// Streams phase sample words through the sample channel, predicts each
// result word from a local copy of the step, stage, slope run and delay sum,
// and checks every result word field by field under random idling and
// register settings that include the extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import ssc_pkg::*;

  localparam int          ClkHalf    = 4;
  localparam int unsigned MaxCycles  = 400000;
  localparam int          IdlePct    = 31;
  localparam int          TailCycles = 8;
  localparam int          SettleGap  = 4;
  localparam int          MaxSample  = 4095;

  // One expected result word.
  typedef struct packed {
    logic [CodeW-1:0] drive_code;
    logic             commutated;
    stage_e           stage_now;
  } drive_word_t;

  // Tracks the commutator state word by word and holds the expected results.
  class commutation_tracker;
    sample_t          hi_min;
    sample_t          lo_max;
    sample_t          zc_level;
    logic [FillW-1:0] fill_level;
    logic [RunW-1:0]  run_len;
    step_t            step_idx;
    stage_e           stage;
    sample_t          prev_flt;
    logic [RunW-1:0]  run_cnt;
    logic [SumW-1:0]  flt_sum;
    drive_word_t      pending_drive[$];
    int unsigned      errors;

    function new();
      hi_min     = HIGH_MIN_RST;
      lo_max     = LOW_MAX_RST;
      zc_level   = ZC_LEVEL_RST;
      fill_level = FILL_RST;
      run_len    = RUN_LEN_RST;
      step_idx   = STEP_FIRST;
      stage      = STAGE_CHECK;
      prev_flt   = PREV_RST;
      run_cnt    = '0;
      flt_sum    = '0;
      errors     = 0;
    endfunction

    // Floating, high and low phase of a step.
    function void roles(input step_t s, output phase_e fp, output phase_e hp,
                        output phase_e lp);
      case (s)
        3'd1:    begin fp = PH_W; hp = PH_U; lp = PH_V; end
        3'd2:    begin fp = PH_V; hp = PH_U; lp = PH_W; end
        3'd3:    begin fp = PH_U; hp = PH_V; lp = PH_W; end
        3'd4:    begin fp = PH_W; hp = PH_V; lp = PH_U; end
        3'd5:    begin fp = PH_V; hp = PH_W; lp = PH_U; end
        default: begin fp = PH_U; hp = PH_W; lp = PH_V; end
      endcase
    endfunction

    function void load_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
      case (idx)
        REG_HIGH_MIN: hi_min     = data[SampleW-1:0];
        REG_LOW_MAX:  lo_max     = data[SampleW-1:0];
        REG_ZC_LEVEL: zc_level   = data[SampleW-1:0];
        REG_FILL:     fill_level = data[FillW-1:0];
        REG_RUN_LEN:  run_len    = data[RunW-1:0];
        default:      ;
      endcase
    endfunction

    function void take_sample(input sample_t u, input sample_t v, input sample_t w);
      sample_t     ph[3];
      phase_e      fp, hp, lp;
      sample_t     f, h, l;
      logic        falling, go, ok, advanced;
      drive_word_t exp_word;
      ph[PH_U] = u;
      ph[PH_V] = v;
      ph[PH_W] = w;
      roles(step_idx, fp, hp, lp);
      f = ph[fp];
      h = ph[hp];
      l = ph[lp];
      falling  = step_idx[0];
      go       = 1'b1;
      advanced = 1'b0;
      if (stage != STAGE_CROSS && stage != STAGE_DELAY) begin
        stage = STAGE_CHECK;
        go    = 1'b0;
        if (h > hi_min && l < lo_max) begin
          ok = falling ? (f < prev_flt) : (f > prev_flt);
          if (ok) begin
            if (run_cnt != RUN_MAX) run_cnt = run_cnt + 1'b1;
            if (run_cnt >= run_len) begin
              run_cnt = '0;
              go      = 1'b1;
            end
          end else begin
            run_cnt = '0;
          end
        end
        prev_flt = f;
        if (go) stage = STAGE_CROSS;
      end
      if (go && stage == STAGE_CROSS) begin
        go = falling ? (f < zc_level) : (f > zc_level);
        if (go) stage = STAGE_DELAY;
      end
      if (go && stage == STAGE_DELAY) begin
        flt_sum = flt_sum + SumW'(f);
        if (flt_sum >= fill_level) begin
          flt_sum  = '0;
          advanced = 1'b1;
        end
      end
      if (advanced) begin
        step_idx = (step_idx == STEP_LAST) ? STEP_FIRST : step_idx + 1'b1;
        stage    = STAGE_CHECK;
      end
      exp_word.drive_code = CodeW'(step_idx) + 1'b1;
      exp_word.commutated = advanced;
      exp_word.stage_now  = stage;
      pending_drive.push_back(exp_word);
    endfunction

    function void match_result(input logic [CodeW-1:0] code, input logic comm,
                               input logic [1:0] stg);
      drive_word_t exp_word;
      if (pending_drive.size() == 0) begin
        $error("result word with no sample outstanding: drive_code %0d", code);
        errors++;
        return;
      end
      exp_word = pending_drive.pop_front();
      if (code !== exp_word.drive_code) begin
        $error("drive_code: expected %0d, actual %0d", exp_word.drive_code, code);
        errors++;
      end
      if (comm !== exp_word.commutated) begin
        $error("commutated: expected %0d, actual %0d", exp_word.commutated, comm);
        errors++;
      end
      if (stg !== exp_word.stage_now) begin
        $error("stage_now: expected %0d, actual %0d", exp_word.stage_now, stg);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_addr;
  logic [CfgDatW-1:0] cfg_wdata;
  logic               steady = 1'b0;  // high: neither side idles
  int unsigned        cycle_cnt = 0;
  commutation_tracker trk;

  ssc_sample_if sample_bus ();
  ssc_result_if result_bus ();

  sensorless_six_step_commutator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_bus),
    .result_o    (result_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Stop a hung run: count every cycle and bail out well past the slowest
  // legal run (about 1800 words, both sides stalling a third of the time).
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MaxCycles) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side back-pressure: drop ready about a third of the time unless
  // the bench is in its steady stretch. Change it on the falling edge only.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_bus.ready = steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Check each result word at the edge where it is taken.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      trk.match_result(result_bus.drive_code, result_bus.commutated, result_bus.stage_now);
    end
  end

  // Offer one sample word, idling first at random; return at the falling
  // edge after the word is taken, valid still high so a following word can
  // go out back to back.
  task automatic send_word(input sample_t u, input sample_t v, input sample_t w);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      sample_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    sample_bus.valid    = 1'b1;
    sample_bus.sample_u = u;
    sample_bus.sample_v = v;
    sample_bus.sample_w = w;
    do @(posedge clk_i); while (sample_bus.ready !== 1'b1);
    trk.take_sample(u, v, w);
    @(negedge clk_i);
  endtask

  // Place floating, high and low values on the phases of the current step.
  task automatic send_roles(input int f, input int h, input int l);
    sample_t ph[3];
    phase_e  fp, hp, lp;
    trk.roles(trk.step_idx, fp, hp, lp);
    ph[fp] = sample_t'(f);
    ph[hp] = sample_t'(h);
    ph[lp] = sample_t'(l);
    send_word(ph[PH_U], ph[PH_V], ph[PH_W]);
  endtask

  // Mostly motor-like words that follow the expected step: high and low
  // phases inside their bands, the floating phase ramping the right way,
  // then crossing the mid level. The rest is noise, extremes and broken
  // bands, plus the odd flat sample that clears the slope run.
  task automatic send_shaped();
    int roll, f, h, l, prev, zc, hmin, lmax, d;
    bit rising;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      send_word(sample_t'($urandom_range(0, MaxSample)), sample_t'($urandom_range(0, MaxSample)),
                sample_t'($urandom_range(0, MaxSample)));
    end else if (roll < 9) begin
      send_word($urandom_range(0, 1) ? sample_t'(MaxSample) : '0,
                $urandom_range(0, 1) ? sample_t'(MaxSample) : '0,
                $urandom_range(0, 1) ? sample_t'(MaxSample) : '0);
    end else begin
      hmin   = trk.hi_min;
      lmax   = trk.lo_max;
      zc     = trk.zc_level;
      prev   = trk.prev_flt;
      rising = !trk.step_idx[0];
      h = (hmin >= MaxSample) ? MaxSample : $urandom_range(hmin + 1, MaxSample);
      l = (lmax == 0) ? 0 : $urandom_range(0, lmax - 1);
      // Push one of the driven phases out of its band.
      if (roll < 13) begin
        if ($urandom_range(0, 1)) h = $urandom_range(0, hmin);
        else l = $urandom_range(lmax, MaxSample);
      end
      case (trk.stage)
        STAGE_CROSS: begin
          if ($urandom_range(0, 99) < 20) f = $urandom_range(0, MaxSample);
          else if (rising) f = (zc >= MaxSample) ? MaxSample : $urandom_range(zc + 1, MaxSample);
          else f = (zc == 0) ? 0 : $urandom_range(0, zc - 1);
        end
        STAGE_DELAY: f = $urandom_range(0, MaxSample);
        default: begin
          d = $urandom_range(1, 150);
          if ($urandom_range(0, 99) < 4) f = prev;
          else if (rising) f = (prev + d <= MaxSample) ? prev + d : $urandom_range(0, 1000);
          else f = (prev >= d) ? prev - d : $urandom_range(3095, MaxSample);
        end
      endcase
      send_roles(f, h, l);
    end
  endtask

  task automatic send_batch(input int n);
    repeat (n) send_shaped();
  endtask

  // Write one register on the next rising edge; the bench is idle here, so
  // update the local copy right away.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    trk.load_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Write all five registers; junk in the unused upper bits must be dropped.
  task automatic load_settings(input int hmin, input int lmax, input int zc, input int fill,
                               input int run);
    write_reg(REG_HIGH_MIN, {4'($urandom), sample_t'(hmin)});
    write_reg(REG_LOW_MAX,  {4'($urandom), sample_t'(lmax)});
    write_reg(REG_ZC_LEVEL, {4'($urandom), sample_t'(zc)});
    write_reg(REG_FILL,     CfgDatW'(fill));
    write_reg(REG_RUN_LEN,  {12'($urandom), 4'(run)});
  endtask

  task automatic load_mid_settings();
    load_settings($urandom_range(1500, 3000), $urandom_range(500, 2000),
                  $urandom_range(1000, 3000), $urandom_range(1, 20000), $urandom_range(1, 6));
  endtask

  // Drop valid and wait until every expected word is back, then give the
  // two-stage pipeline a few more cycles before touching the registers.
  task automatic settle();
    sample_bus.valid = 1'b0;
    while (trk.pending_drive.size() != 0) @(negedge clk_i);
    repeat (SettleGap) @(negedge clk_i);
  endtask

  initial begin
    trk                 = new();
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_addr            = REG_HIGH_MIN;
    cfg_wdata           = '0;
    sample_bus.valid    = 1'b0;
    sample_bus.sample_u = '0;
    sample_bus.sample_v = '0;
    sample_bus.sample_w = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings. Hit the field extremes first: each fails a
    // band but still moves the previous floating sample.
    send_word('0, '0, '0);
    send_word(sample_t'(MaxSample), sample_t'(MaxSample), sample_t'(MaxSample));
    send_word(sample_t'(MaxSample), '0, '0);
    send_word('0, sample_t'(MaxSample), sample_t'(MaxSample));
    // Step 0 rising: three climbing words confirm the slope and cross the
    // mid level at once, then fill the delay and commutate.
    send_roles(2100, 3000, 500);
    send_roles(2200, 3000, 500);
    send_roles(2300, 3000, 500);
    send_roles(MaxSample, MaxSample, 0);
    send_roles(MaxSample, MaxSample, 0);
    // Step 1 falling, with a zero floating sample inside the delay.
    send_roles(2000, 3000, 100);
    send_roles(1900, 3000, 100);
    send_roles(1800, 3000, 100);
    send_roles(0, 3000, 100);
    send_roles(MaxSample, 3000, 100);
    send_roles(MaxSample, 3000, 100);
    send_roles(MaxSample, 3000, 100);
    // Step 2: high at its threshold, low at its threshold (count held),
    // then a flat sample and a wrong-way sample that clear the run.
    send_roles(2400, 2457, 100);
    send_roles(2500, 3000, 1638);
    send_roles(2500, 3000, 100);
    send_roles(2600, 3000, 100);
    send_roles(2500, 3000, 100);
    settle();

    // Zero run length and zero fill level: one good word commutates.
    load_settings(HIGH_MIN_RST, LOW_MAX_RST, ZC_LEVEL_RST, 0, 0);
    send_roles(2700, 3000, 100);
    send_roles(100, 3000, 100);
    send_batch(270);
    settle();

    load_mid_settings();
    send_batch(300);
    settle();

    // Widest bands, lowest limits; run with no idling on either side.
    steady = 1'b1;
    load_settings(0, MaxSample, 1, 1, 1);
    send_batch(250);
    settle();
    steady = 1'b0;

    // Narrowest usable bands, longest run and largest fill level.
    load_settings(MaxSample - 1, 1, MaxSample - 1, 16'hFFFF, 15);
    send_batch(250);
    settle();

    // Bands that can never be met: once back in checking, the block must stay there.
    load_settings(MaxSample, 0, 0, 0, 0);
    send_batch(60);
    settle();

    // Writes past the last register must change nothing.
    load_mid_settings();
    write_reg(CfgIdxW'(REG_RUN_LEN) + CfgIdxW'($urandom_range(1, 3)), CfgDatW'($urandom));
    write_reg(CfgIdxW'(REG_RUN_LEN) + CfgIdxW'($urandom_range(1, 3)), CfgDatW'($urandom));
    send_batch(300);
    settle();

    load_settings(HIGH_MIN_RST, LOW_MAX_RST, ZC_LEVEL_RST, FILL_RST, RUN_LEN_RST);
    send_batch(300);
    settle();

    // Let any stray word surface before the verdict.
    repeat (TailCycles) @(negedge clk_i);
    if (trk.errors == 0 && trk.pending_drive.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ssc_pkg.sv
design/ssc_sample_if.sv
design/ssc_result_if.sv
design/sensorless_six_step_commutator.sv
tb/sv/tb_top.sv
